>>> rtl/core/dlr_pkg.sv
`timescale 1ns / 1ps
// Package for the DLE/ETX link receiver: codes, command type and defaults.
// Used by the front, queue, back and top files; depends on nothing.
package dlr_pkg;

  // Link control characters
  localparam logic [7:0] DLE = 8'd16;
  localparam logic [7:0] ETX = 8'd3;
  localparam logic [7:0] FRAME_LEN = 8'd2;

  // Defaults for top-level parameters
  localparam int SCAN_LIMIT_DEF  = 255;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Configuration register indexes and reset values
  localparam logic [1:0] REG_RETRY_LIMIT = 2'd0;
  localparam logic [1:0] REG_ACK_ID      = 2'd1;
  localparam logic [1:0] REG_NAK_ID      = 2'd2;
  localparam logic [7:0] RETRY_LIMIT_RST = 8'd3;
  localparam logic [7:0] ACK_ID_RST      = 8'd6;
  localparam logic [7:0] NAK_ID_RST      = 8'd21;

  typedef struct packed {
    logic [7:0] retry_limit;
    logic [7:0] ack_id;
    logic [7:0] nak_id;
  } cfg_t;

  // Result kinds on the output channel
  typedef enum logic [1:0] {
    K_PAYLOAD = 2'd0,
    K_TX      = 2'd1,
    K_VERDICT = 2'd2
  } kind_t;

  // Packet verdicts
  typedef enum logic [2:0] {
    V_GOOD    = 3'd0,
    V_STUFF   = 3'd1,
    V_CKSUM   = 3'd2,
    V_FRAME   = 3'd3,
    V_RETRIES = 3'd4,
    V_SCAN    = 3'd5
  } verdict_t;

  // Receive parser phases
  typedef enum logic [2:0] {
    PH_HUNT,
    PH_HUNT_DLE,
    PH_SIZE,
    PH_PAYLOAD,
    PH_CKSUM,
    PH_END1,
    PH_END2_OK,
    PH_END2_BAD
  } phase_t;

  // Commands from front to back
  typedef enum logic [1:0] {
    C_PAYLOAD,
    C_FINISH,
    C_FATAL
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
    logic [7:0] id;
    logic [7:0] size;
    verdict_t   verdict;
  } cmd_t;

  // Back-end output sequencer steps
  typedef enum logic [3:0] {
    ST_HEAD,
    ST_DLE1,
    ST_PID,
    ST_LEN,
    ST_ID,
    ST_ZERO,
    ST_STUFF,
    ST_CK,
    ST_DLE2,
    ST_ETX
  } step_t;

endpackage

>>> rtl/core/dlr_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for received bytes and for results.
// Standalone; widths follow the link byte and result fields.
interface dlr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface dlr_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic [7:0] hdr_id;
  logic [7:0] packet_size;
  logic [2:0] verdict;
  logic       last;

  modport source (output valid, output out_kind, output out_byte, output hdr_id,
                  output packet_size, output verdict, output last, input ready);
  modport sink   (input valid, input out_kind, input out_byte, input hdr_id,
                  input packet_size, input verdict, input last, output ready);
endinterface

>>> rtl/core/dlr_front.sv
`timescale 1ns / 1ps
// Front end: parses received bytes, tracks packet state and counters,
// and pushes one command per byte that yields results. Uses dlr_pkg, dlr_if.
module dlr_front
  import dlr_pkg::*;
#(
  parameter int SCAN_LIMIT = SCAN_LIMIT_DEF
) (
  input  logic          clk,
  input  logic          rst,
  dlr_rx_if.sink        rx,
  input  logic [7:0]    retry_limit,
  input  logic          queue_full,
  output logic          cmd_valid,
  output cmd_t          cmd
);

  localparam int SCW = $clog2(SCAN_LIMIT + 3);

  phase_t         phase, phase_next;
  logic [SCW-1:0] scanned_count, scanned_count_next;
  logic [7:0]     failure_count, failure_count_next;
  logic [7:0]     current_id, current_id_next;
  logic [7:0]     current_size, current_size_next;
  logic [7:0]     payload_remaining, payload_remaining_next;
  logic [7:0]     running_sum, running_sum_next;
  logic           expect_dle, expect_dle_next;

  logic           accept;
  logic [7:0]     b;
  logic [7:0]     want;
  logic           do_finish, do_fatal, do_payload;
  verdict_t       fin_verdict;

  assign rx.ready = !queue_full;
  assign accept   = rx.valid && rx.ready;
  assign b        = rx.rx_byte;
  assign want     = 8'(~running_sum + 8'd1);

  // Next state of the parser
  always_comb begin
    phase_next             = phase;
    scanned_count_next     = scanned_count;
    failure_count_next     = failure_count;
    current_id_next        = current_id;
    current_size_next      = current_size;
    payload_remaining_next = payload_remaining;
    running_sum_next       = running_sum;
    expect_dle_next        = expect_dle;
    do_finish              = 1'b0;
    do_fatal               = 1'b0;
    do_payload             = 1'b0;
    fin_verdict            = V_GOOD;
    if (accept) begin
      unique case (phase)
        PH_HUNT: begin
          if (failure_count >= retry_limit) begin
            do_fatal           = 1'b1;
            fin_verdict        = V_RETRIES;
            scanned_count_next = '0;
            failure_count_next = '0;
          end else if (scanned_count > SCW'(SCAN_LIMIT)) begin
            do_fatal           = 1'b1;
            fin_verdict        = V_SCAN;
            scanned_count_next = '0;
            failure_count_next = '0;
          end else begin
            scanned_count_next = scanned_count + 1'b1;
            phase_next         = (b == DLE) ? PH_HUNT_DLE : PH_HUNT;
          end
        end
        PH_HUNT_DLE: begin
          scanned_count_next = scanned_count + 1'b1;
          if (b == DLE || b == ETX) begin
            phase_next = PH_HUNT;
          end else begin
            current_id_next = b;
            expect_dle_next = 1'b0;
            phase_next      = PH_SIZE;
          end
        end
        PH_SIZE: begin
          current_size_next = b;
          if (expect_dle && b != DLE) begin
            do_finish   = 1'b1;
            fin_verdict = V_STUFF;
          end else if (!expect_dle && b == DLE) begin
            expect_dle_next = 1'b1;
          end else begin
            expect_dle_next        = 1'b0;
            running_sum_next       = current_id + b;
            payload_remaining_next = b;
            phase_next             = (b == 8'd0) ? PH_CKSUM : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          if (expect_dle) begin
            expect_dle_next = 1'b0;
            if (b != DLE) begin
              do_finish   = 1'b1;
              fin_verdict = V_STUFF;
            end else if (payload_remaining == 8'd0) begin
              phase_next = PH_CKSUM;
            end
          end else begin
            do_payload             = 1'b1;
            running_sum_next       = running_sum + b;
            payload_remaining_next = payload_remaining - 8'd1;
            if (b == DLE) begin
              expect_dle_next = 1'b1;
            end else if (payload_remaining == 8'd1) begin
              phase_next = PH_CKSUM;
            end
          end
        end
        PH_CKSUM: begin
          if (expect_dle) begin
            expect_dle_next = 1'b0;
            if (b != DLE) begin
              do_finish   = 1'b1;
              fin_verdict = V_STUFF;
            end else if (want != DLE) begin
              do_finish   = 1'b1;
              fin_verdict = V_CKSUM;
            end else begin
              phase_next = PH_END1;
            end
          end else if (b == DLE) begin
            expect_dle_next = 1'b1;
          end else if (b != want) begin
            do_finish   = 1'b1;
            fin_verdict = V_CKSUM;
          end else begin
            phase_next = PH_END1;
          end
        end
        PH_END1: begin
          phase_next = (b == DLE) ? PH_END2_OK : PH_END2_BAD;
        end
        PH_END2_OK: begin
          do_finish   = 1'b1;
          fin_verdict = (b == ETX) ? V_GOOD : V_FRAME;
        end
        PH_END2_BAD: begin
          do_finish   = 1'b1;
          fin_verdict = V_FRAME;
        end
        default: begin
          phase_next = PH_HUNT;
        end
      endcase

      // Packet end: verdict, counters and return to hunting
      if (do_finish) begin
        if (fin_verdict == V_GOOD) begin
          failure_count_next = '0;
        end else if (failure_count != 8'hFF) begin
          failure_count_next = failure_count + 8'd1;
        end
        scanned_count_next = '0;
        expect_dle_next    = 1'b0;
        phase_next         = PH_HUNT;
      end
    end
  end

  // Command toward the queue
  always_comb begin
    cmd_valid   = do_finish || do_fatal || do_payload;
    cmd.kind    = do_payload ? C_PAYLOAD : (do_fatal ? C_FATAL : C_FINISH);
    cmd.data    = b;
    cmd.id      = current_id_next;
    cmd.size    = current_size_next;
    cmd.verdict = fin_verdict;
  end

  // Parser registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HUNT;
      scanned_count     <= '0;
      failure_count     <= '0;
      current_id        <= '0;
      current_size      <= '0;
      payload_remaining <= '0;
      running_sum       <= '0;
      expect_dle        <= 1'b0;
    end else begin
      phase             <= phase_next;
      scanned_count     <= scanned_count_next;
      failure_count     <= failure_count_next;
      current_id        <= current_id_next;
      current_size      <= current_size_next;
      payload_remaining <= payload_remaining_next;
      running_sum       <= running_sum_next;
      expect_dle        <= expect_dle_next;
    end
  end

  // Any verdict sends the parser back to hunting
  a_finish_hunt: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd.kind != C_PAYLOAD) |=> (phase == PH_HUNT && !expect_dle))
    else $error("parser did not return to hunting after a verdict");

  // The scan counter never runs past the limit check
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    scanned_count <= SCW'(SCAN_LIMIT + 2))
    else $error("scan counter beyond limit");

endmodule

>>> rtl/core/dlr_queue.sv
`timescale 1ns / 1ps
// Short command queue between parser and output sequencer.
// Uses dlr_pkg for the command type.
module dlr_queue
  import dlr_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Storage write
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("command pushed into full queue");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> count == $past(count) + CW'($past(do_push)) - CW'($past(do_pop)))
    else $error("queue count out of step with transactions");

endmodule

>>> rtl/core/dlr_back.sv
`timescale 1ns / 1ps
// Back end: expands queued commands into result transactions, including
// the ACK/NAK frame after a packet-end verdict (none after a fatal one). Uses dlr_pkg and dlr_if.
module dlr_back
  import dlr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  cmd_t       head,
  input  logic [7:0] ack_id,
  input  logic [7:0] nak_id,
  output logic       pop,
  dlr_res_if.source  res
);

  step_t      step, step_next;
  logic [7:0] pid;
  logic [7:0] ck;
  logic       fire;

  assign pid  = (head.verdict == V_GOOD) ? ack_id : nak_id;
  assign ck   = 8'(~(pid + FRAME_LEN + head.id) + 8'd1);
  assign fire = res.valid && res.ready;

  // Next step of the sequencer
  always_comb begin
    step_next = step;
    if (fire) begin
      unique case (step)
        ST_HEAD:  step_next = (head.kind == C_FINISH) ? ST_DLE1 : ST_HEAD;
        ST_DLE1:  step_next = ST_PID;
        ST_PID:   step_next = ST_LEN;
        ST_LEN:   step_next = ST_ID;
        ST_ID:    step_next = ST_ZERO;
        ST_ZERO:  step_next = (ck == DLE) ? ST_STUFF : ST_CK;
        ST_STUFF: step_next = ST_CK;
        ST_CK:    step_next = ST_DLE2;
        ST_DLE2:  step_next = ST_ETX;
        ST_ETX:   step_next = ST_HEAD;
        default:  step_next = ST_HEAD;
      endcase
    end
  end

  // Result fields for the current step
  always_comb begin
    res.valid       = head_valid;
    res.hdr_id      = head.id;
    res.packet_size = head.size;
    res.out_kind    = K_TX;
    res.out_byte    = '0;
    res.verdict     = V_GOOD;
    res.last        = 1'b0;
    unique case (step)
      ST_HEAD: begin
        if (head.kind == C_PAYLOAD) begin
          res.out_kind = K_PAYLOAD;
          res.out_byte = head.data;
          res.last     = 1'b1;
        end else begin
          res.out_kind = K_VERDICT;
          res.verdict  = head.verdict;
          res.last     = (head.kind == C_FATAL);
        end
      end
      ST_DLE1:  res.out_byte = DLE;
      ST_PID:   res.out_byte = pid;
      ST_LEN:   res.out_byte = FRAME_LEN;
      ST_ID:    res.out_byte = head.id;
      ST_ZERO:  res.out_byte = '0;
      ST_STUFF: res.out_byte = DLE;
      ST_CK:    res.out_byte = ck;
      ST_DLE2:  res.out_byte = DLE;
      ST_ETX: begin
        res.out_byte = ETX;
        res.last     = 1'b1;
      end
      default:  res.out_byte = '0;
    endcase
    pop = fire && res.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_HEAD;
    end else begin
      step <= step_next;
    end
  end

  // A frame is only walked for a packet-end (finish) verdict command
  a_frame_from_finish: assert property (@(posedge clk) disable iff (rst)
    (step != ST_HEAD) |-> (head_valid && head.kind == C_FINISH))
    else $error("frame sequencing without a verdict command");

  // Stuffed checksum step only when the checksum is DLE
  a_stuff_only_dle: assert property (@(posedge clk) disable iff (rst)
    (step == ST_STUFF) |-> (ck == DLE))
    else $error("checksum stuffing without DLE checksum");

endmodule

>>> rtl/core/dle_link_receiver_with_ack_unit.sv
`timescale 1ns / 1ps
// DLE/ETX link receiver top: config registers, parser, command queue, sequencer.
// A result is registered in the command queue before the sequencer presents it.
// The parser takes one received byte per cycle while the command queue has room; the
// sequencer drains one result per cycle while res.ready is high, a finish verdict then its frame.
// Reset (rst, synchronous): parser hunts, counters clear, queue empties,
// retry_limit 3, ack id 6, nak id 21. Uses dlr_pkg, dlr_if, dlr_front/queue/back.
module dle_link_receiver_with_ack_unit
  import dlr_pkg::*;
#(
  parameter int SCAN_LIMIT  = SCAN_LIMIT_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  dlr_rx_if.sink     rx,
  dlr_res_if.source  res,
  input  logic       wr_en,
  input  logic [1:0] wr_index,
  input  logic [7:0] wr_data
);

  cfg_t cfg;
  logic queue_full;
  logic cmd_valid;
  cmd_t cmd;
  logic head_valid;
  cmd_t head;
  logic pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.retry_limit <= RETRY_LIMIT_RST;
      cfg.ack_id      <= ACK_ID_RST;
      cfg.nak_id      <= NAK_ID_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_RETRY_LIMIT: cfg.retry_limit <= wr_data;
        REG_ACK_ID:      cfg.ack_id      <= wr_data;
        REG_NAK_ID:      cfg.nak_id      <= wr_data;
        default:         cfg             <= cfg;
      endcase
    end
  end

  dlr_front #(
    .SCAN_LIMIT (SCAN_LIMIT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .rx          (rx),
    .retry_limit (cfg.retry_limit),
    .queue_full  (queue_full),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd)
  );

  dlr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (cmd_valid),
    .push_data  (cmd),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  dlr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .ack_id     (cfg.ack_id),
    .nak_id     (cfg.nak_id),
    .pop        (pop),
    .res        (res)
  );

endmodule
